@@ hdl/ebc_pkg.sv @@
package ebc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int IDX_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int CW = 34;
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] ANG_PI = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(64'sd843314857);
  localparam logic [63:0] GAIN_TAIL = 64'd434688583;
  localparam logic [63:0] GAIN_SUM = 64'd652032874 + (GAIN_TAIL >> (2 * CORDIC_STAGES));
  localparam logic signed [CW-1:0] GAIN_K = CW'(GAIN_SUM);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
    logic [30:0]          ew;
    logic [30:0]          eh;
    logic signed [31:0]   cx;
    logic signed [31:0]   cy;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (32'(i))
      0: r = ZW'(64'sd421657428);
      1: r = ZW'(64'sd248918915);
      2: r = ZW'(64'sd131521918);
      3: r = ZW'(64'sd66762579);
      4: r = ZW'(64'sd33510841);
      5: r = ZW'(64'sd16771758);
      6: r = ZW'(64'sd8387925);
      7: r = ZW'(64'sd4194219);
      8: r = ZW'(64'sd2097141);
      9: r = ZW'(64'sd1048575);
      default: begin
        if (32'(i) <= 29) r = ZW'(64'sd1) <<< (29 - 32'(i));
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/expanded_rotated_box_corners_top.sv @@
// Expanded rotated box corners.
// Input channel: one beat per box (centre, width, height, rotation), taken
// when in_valid_i is high and in_stall_o low. Output channel: four beats per
// box, corners 0..3 in order, last_corner_o high on the fourth, taken when
// out_valid_o is high and out_stall_i low.
// margin_x and margin_y are written over the APB port (byte addresses 0 and 4);
// the user must write them only while the block is idle, which the block
// itself does not enforce. Both reset to 0. An accepted box passes through
// the 16 CORDIC cells, three product/sum/round stages and one output register
// before its first corner beat. The single output register sends all four
// corner beats of a box before it takes the next finished box.
// The pipeline keeps taking boxes while a finished box waits in the output
// register; the whole pipeline holds, and in_stall_o is raised, once a
// further finished box waits behind it and the output register is not free.
// Reset clears all valid state and empties the pipeline.
module expanded_rotated_box_corners_top
  import ebc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [29:0]        box_width_i,
  input  logic [29:0]        box_height_i,
  input  logic signed [15:0] rotation_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] corner_x_o,
  output logic signed [31:0] corner_y_o,
  output logic [1:0]         corner_index_o,
  output logic               last_corner_o
);

  localparam logic REG_MARGIN_X = 1'b0;
  localparam logic REG_MARGIN_Y = 1'b1;
  localparam logic [1:0] LAST_IDX = 2'd3;

  logic [28:0] margin_x_q, margin_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_x_q <= '0;
      margin_y_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MARGIN_X: margin_x_q <= pwdata[28:0];
        REG_MARGIN_Y: margin_y_q <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MARGIN_Y) ? {3'b0, margin_y_q} : {3'b0, margin_x_q};

  logic  adv;
  cell_t head;
  logic signed [ZW-1:0] z0;

  always_comb begin
    z0 = {{(ZW-32){rotation_i[15]}}, rotation_i, 16'b0};
    head.neg = 1'b0;
    head.z   = z0;
    if (z0 > ANG_HALF_PI) begin
      head.z   = z0 - ANG_PI;
      head.neg = 1'b1;
    end else if (z0 < -ANG_HALF_PI) begin
      head.z   = z0 + ANG_PI;
      head.neg = 1'b1;
    end
    head.x  = GAIN_K;
    head.y  = '0;
    head.ew = {1'b0, box_width_i} + {1'b0, margin_x_q, 1'b0};
    head.eh = {1'b0, box_height_i} + {1'b0, margin_y_q, 1'b0};
    head.cx = center_x_i;
    head.cy = center_y_i;
  end

  cell_t pipe [CORDIC_STAGES+1];
  logic  pvld [CORDIC_STAGES+1];

  assign pipe[0] = head;
  assign pvld[0] = in_valid_i;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ebc_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (IDX_W'(i)),
      .vld_i  (pvld[i]),
      .data_i (pipe[i]),
      .vld_o  (pvld[i+1]),
      .data_o (pipe[i+1])
    );
  end

  logic               cvld;
  logic signed [31:0] cxs [4];
  logic signed [31:0] cys [4];

  ebc_corner u_corner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (pvld[CORDIC_STAGES]),
    .data_i (pipe[CORDIC_STAGES]),
    .vld_o  (cvld),
    .xs_o   (cxs),
    .ys_o   (cys)
  );

  logic               out_vld_q;
  logic [1:0]         cnt_q;
  logic signed [31:0] xs_q [4];
  logic signed [31:0] ys_q [4];
  logic               ser_free;

  assign ser_free   = !out_vld_q || (!out_stall_i && cnt_q == LAST_IDX);
  assign adv        = !cvld || ser_free;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else if (cvld && ser_free) begin
      out_vld_q <= 1'b1;
      cnt_q     <= '0;
    end else if (out_vld_q && !out_stall_i) begin
      if (cnt_q == LAST_IDX) out_vld_q <= 1'b0;
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cvld && ser_free) begin
      xs_q <= cxs;
      ys_q <= cys;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign corner_x_o     = xs_q[cnt_q];
  assign corner_y_o     = ys_q[cnt_q];
  assign corner_index_o = cnt_q;
  assign last_corner_o  = (cnt_q == LAST_IDX);

endmodule

@@ hdl/ebc_cordic_cell.sv @@
module ebc_cordic_cell
  import ebc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             vld_i,
  input  cell_t            data_i,
  output logic             vld_o,
  output cell_t            data_o
);

  logic  vld_q;
  cell_t data_q, data_d;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  always_comb begin
    dx = data_i.y >>> idx_i;
    dy = data_i.x >>> idx_i;
    at = atan_entry(idx_i);
    data_d = data_i;
    if (data_i.z >= 0) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

@@ hdl/ebc_corner.sv @@
module ebc_corner
  import ebc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               vld_i,
  input  cell_t              data_i,
  output logic               vld_o,
  output logic signed [31:0] xs_o [4],
  output logic signed [31:0] ys_o [4]
);

  logic [2:0] vld_q;

  // products
  logic signed [CW-1:0] cn, sn;
  logic signed [31:0]   c32, s32, ew_s, eh_s;
  logic signed [63:0]   p_q, q_q, r_q, t_q;
  logic signed [31:0]   cx1_q, cy1_q, cx2_q, cy2_q;

  // sums
  logic signed [65:0] d_x, s_x, d_y, s_y;
  logic signed [65:0] xv_q [4];
  logic signed [65:0] yv_q [4];

  logic signed [31:0] xs_q [4];
  logic signed [31:0] ys_q [4];

  function automatic logic signed [31:0] place(input logic signed [65:0] v,
                                               input logic signed [31:0] c);
    logic signed [65:0] t;
    logic signed [34:0] r;
    logic signed [35:0] s;
    logic signed [31:0] o;
    t = v + 66'sh40000000;
    r = t[65:31];
    s = 36'(r) + 36'(c);
    if (s > 36'sd2147483647) o = 32'sh7fffffff;
    else if (s < -36'sd2147483648) o = 32'sh80000000;
    else o = s[31:0];
    return o;
  endfunction

  always_comb begin
    cn   = data_i.neg ? -data_i.x : data_i.x;
    sn   = data_i.neg ? -data_i.y : data_i.y;
    c32  = cn[31:0];
    s32  = sn[31:0];
    ew_s = $signed({1'b0, data_i.ew});
    eh_s = $signed({1'b0, data_i.eh});
    d_x  = 66'(p_q) - 66'(q_q);
    s_x  = 66'(p_q) + 66'(q_q);
    d_y  = 66'(r_q) - 66'(t_q);
    s_y  = 66'(r_q) + 66'(t_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q   <= ew_s * c32;
      q_q   <= eh_s * s32;
      r_q   <= ew_s * s32;
      t_q   <= eh_s * c32;
      cx1_q <= data_i.cx;
      cy1_q <= data_i.cy;
      xv_q[0] <= -d_x;
      xv_q[1] <= s_x;
      xv_q[2] <= d_x;
      xv_q[3] <= -s_x;
      yv_q[0] <= -s_y;
      yv_q[1] <= d_y;
      yv_q[2] <= s_y;
      yv_q[3] <= -d_y;
      cx2_q <= cx1_q;
      cy2_q <= cy1_q;
      for (int k = 0; k < 4; k++) begin
        xs_q[k] <= place(xv_q[k], cx2_q);
        ys_q[k] <= place(yv_q[k], cy2_q);
      end
    end
  end

  assign vld_o = vld_q[2];
  assign xs_o  = xs_q;
  assign ys_o  = ys_q;

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAGES = 16;
  localparam longint PI_Q29 = 1686629713;
  localparam longint HALF_PI_Q29 = 843314857;
  localparam logic [2:0] ADDR_MARGIN_X = 3'd0;
  localparam logic [2:0] ADDR_MARGIN_Y = 3'd4;
  localparam int LATENCY = 20;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [1:0]         idx;
    logic               last;
  } corner_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [31:0] center_x_i = '0, center_y_i = '0;
  logic [29:0] box_width_i = '0, box_height_i = '0;
  logic signed [15:0] rotation_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [31:0] corner_x_o, corner_y_o;
  logic [1:0] corner_index_o;
  logic last_corner_o;

  corner_t expected_corners[$];
  longint margin_x_q = 0, margin_y_q = 0;
  int errors = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit rx_random = 1;

  expanded_rotated_box_corners_top dut (.*);

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q29(int i);
    longint head[10] = '{421657428, 248918915, 131521918, 66762579, 33510841,
                         16771758, 8387925, 4194219, 2097141, 1048575};
    if (i < 10) return head[i];
    if (i <= 29) return longint'(1) << (29 - i);
    return 0;
  endfunction

  function automatic logic [31:0] place_corner(longint prod, longint centre);
    longint v;
    v = floor_shr(prod + (longint'(1) << 30), 31) + centre;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_corners(logic signed [31:0] cx, logic signed [31:0] cy,
                                 logic [29:0] w, logic [29:0] h,
                                 logic signed [15:0] rot);
    longint z, x, y, dx, dy, ew, eh, hx, hy;
    bit neg;
    corner_t c;
    int sx[4] = '{-1, 1, 1, -1};
    int sy[4] = '{-1, -1, 1, 1};
    neg = 0;
    z = longint'(rot) * 65536;
    if (z > HALF_PI_Q29) begin z -= PI_Q29; neg = 1; end
    else if (z < -HALF_PI_Q29) begin z += PI_Q29; neg = 1; end
    x = 652032874 + (434688583 >> (2 * NSTAGES));
    y = 0;
    for (int i = 0; i < NSTAGES; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q29(i);
      end else begin
        x += dx; y -= dy; z += atan_q29(i);
      end
    end
    if (neg) begin x = -x; y = -y; end
    ew = longint'(w) + 2 * margin_x_q;
    eh = longint'(h) + 2 * margin_y_q;
    for (int k = 0; k < 4; k++) begin
      hx = sx[k] * ew;
      hy = sy[k] * eh;
      c.x = place_corner(hx * x - hy * y, longint'(cx));
      c.y = place_corner(hx * y + hy * x, longint'(cy));
      c.idx = k[1:0];
      c.last = (k == 3);
      expected_corners = {expected_corners, c};
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  // result checker
  always @(posedge clk_i) begin
    corner_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_corners.size() == 0) begin
        report_mismatch("unexpected beat, index", corner_index_o, -1);
      end else begin
        e = expected_corners.pop_front();
        if (corner_x_o !== e.x) report_mismatch("corner_x", corner_x_o, e.x);
        if (corner_y_o !== e.y) report_mismatch("corner_y", corner_y_o, e.y);
        if (corner_index_o !== e.idx) report_mismatch("corner_index", corner_index_o, e.idx);
        if (last_corner_o !== e.last) report_mismatch("last_corner", last_corner_o, e.last);
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else if (rx_random) begin
      if ($urandom_range(0, 99) < 3) out_stall_i <= ($urandom_range(0, 1) == 1);
      else if ($urandom_range(0, 99) < 25) out_stall_i <= 1;
      else out_stall_i <= 0;
    end else begin
      out_stall_i <= 0;
    end
  end

  task automatic idle_gap();
    int r;
    int n;
    r = int'($urandom_range(0, 99));
    if (r < 55) n = 0;
    else if (r < 92) n = int'($urandom_range(1, 3));
    else n = int'($urandom_range(8, 40));
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_box(logic signed [31:0] cx, logic signed [31:0] cy,
                          logic [29:0] w, logic [29:0] h, logic signed [15:0] rot,
                          bit gaps = 1);
    if (gaps) idle_gap();
    in_valid_i <= 1;
    center_x_i <= cx;
    center_y_i <= cy;
    box_width_i <= w;
    box_height_i <= h;
    rotation_i <= rot;
    do @(posedge clk_i); while (in_stall_o);
    predict_corners(cx, cy, w, h, rot);
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    while (expected_corners.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [2:0] addr, logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_MARGIN_X) margin_x_q = value & 32'h1FFF_FFFF;
    else margin_y_q = value & 32'h1FFF_FFFF;
    @(posedge clk_i);
  endtask

  task automatic set_margins(logic [31:0] mx, logic [31:0] my);
    wait_drained();
    write_margin(ADDR_MARGIN_X, mx);
    write_margin(ADDR_MARGIN_Y, my);
  endtask

  task automatic send_random_box();
    logic [29:0] w, h;
    logic signed [15:0] rot;
    case ($urandom_range(0, 5))
      0: w = 30'($urandom);
      1: w = 30'($urandom_range(0, 255));
      default: w = 30'($urandom_range(0, 32'h00FF_FFFF));
    endcase
    h = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(0, 32'h00FF_FFFF));
    rot = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 51472) - 25736);
    send_box($urandom, $urandom, w, h, rot);
  endtask

  task automatic test_directed();
    send_box(0, 0, 0, 0, 0);
    send_box(32'sh0001_0000, -32'sh0002_0000, 30'h0004_0000, 30'h0002_0000, 16'sd6434);
    send_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 0);
    send_box(32'sh8000_0000, 32'sh8000_0000, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 0);
    send_box(0, 0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 16'sd25736);
    send_box(0, 0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, -16'sd25736);
    send_box(100, -100, 30'h0010_0000, 30'h0008_0000, 16'sd12868);
    send_box(100, -100, 30'h0010_0000, 30'h0008_0000, -16'sd12868);
    send_box(100, -100, 30'h0010_0000, 30'h0008_0000, 16'sd12869);
    send_box(100, -100, 30'h0010_0000, 30'h0008_0000, -16'sd12869);
    send_box(-5, 5, 30'h0010_0000, 30'h0008_0000, 16'sh7FFF);
    send_box(-5, 5, 30'h0010_0000, 30'h0008_0000, 16'sh8000);
    send_box(32'sh5555_5555, 32'shAAAA_AAAA, 30'h2AAA_AAAA, 30'h1555_5555, 16'sh5555);
    send_box(32'shAAAA_AAAA, 32'sh5555_5555, 30'h1555_5555, 30'h2AAA_AAAA, 16'shAAAA);
    send_box(0, 0, 1, 1, 1);
    send_box(0, 0, 3, 3, -1);
  endtask

  task automatic test_margins();
    set_margins(32'h1FFF_FFFF, 32'h1FFF_FFFF);
    send_box(32'sh7FFF_FFFF, 32'sh8000_0000, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 16'sd3000);
    send_box(0, 0, 0, 0, -16'sd20000);
    set_margins(32'hFFFF_FFFF, 32'h0000_0001);
    send_box(0, 0, 10, 10, 16'sd1000);
    set_margins(32'h0001_8000, 0);
    repeat (20) send_random_box();
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      set_margins($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000));
      repeat (100) send_random_box();
    end
    set_margins(0, 0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_off = 300;
    repeat (30) send_box($urandom, $urandom, 30'($urandom_range(0, 65535)),
                         30'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 51472) - 25736), 0);
    wait_drained();
    rx_random = 0;
    repeat (10) send_random_box();
    rx_random = 1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    test_margins();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
